>>> rtl/core/cps_pkg.sv
// Shared constants, codes and item types of the CIGAR pileup scorer.
package cps_pkg;

    localparam int MAX_REF_LEN = 65536;
    localparam int NUM_REFS    = 4;
    localparam int POS_W       = $clog2(MAX_REF_LEN);
    localparam int SLOT_W      = $clog2(NUM_REFS);
    localparam int ADDR_W      = SLOT_W + POS_W;
    localparam int DEPTH       = NUM_REFS * MAX_REF_LEN;
    localparam int LEN_W       = POS_W + 1;
    localparam int RUN_W       = 16;
    localparam int CUR_W       = 18;
    localparam int WT_W        = 8;
    localparam int CFG_IDX_W   = 2;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_REF_LEN);
    localparam logic [RUN_W-1:0] RUN_MAX = '1;
    localparam logic [CUR_W-1:0] CUR_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MISMATCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_OPEN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_EXT  = 2'd3;

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_M  = 8'h4D;
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_D  = 8'h44;
    localparam logic [7:0] CH_N  = 8'h4E;
    localparam logic [7:0] CH_X  = 8'h58;
    localparam logic [7:0] CH_I  = 8'h49;

    localparam logic KIND_SCORE = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    typedef enum logic [1:0] {
        FUNC_CHAR = 2'd0,
        FUNC_READ = 2'd1,
        FUNC_LEN  = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    typedef struct packed {
        t_func             func;
        logic [7:0]        ch;
        logic [SLOT_W-1:0] ref_slot;
        logic [16:0]       position;
        logic              first_char;
        logic              last_char;
    } t_in_item;

    typedef struct packed {
        logic               kind;
        logic signed [31:0] align_score;
        logic signed [31:0] entry_score;
        logic [31:0]        entry_coverage;
    } t_out_item;

    typedef struct packed {
        logic take_item;
        logic exec;
        logic run_step;
        logic clear;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic  clear_last;
        logic  cover_end;
        t_func func;
        logic  last_char;
        logic  cover_op;
        logic  out_free;
    } t_stat;

endpackage

>>> rtl/core/cps_ctrl.sv
// Controller state machine of the CIGAR pileup scorer.
module cps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  cps_pkg::t_stat i_stat,
    output cps_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_COVER,
        S_EMIT
    } t_state;

    t_state r_state;

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cmd.take_item = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec      = (r_state == S_EXEC);
    assign o_cmd.run_step  = (r_state == S_COVER);
    assign o_cmd.clear     = (r_state == S_CLEAR);
    assign o_cmd.emit      = (r_state == S_EMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (i_stat.clear_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (i_stat.func)
                        cps_pkg::FUNC_CHAR: begin
                            if (i_stat.cover_op) begin
                                r_state <= S_COVER;
                            end else if (i_stat.last_char) begin
                                r_state <= S_EMIT;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end
                        cps_pkg::FUNC_READ: begin
                            r_state <= S_EMIT;
                        end
                        cps_pkg::FUNC_LEN,
                        cps_pkg::FUNC_NONE: begin
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_COVER: begin
                    if (i_stat.cover_end) begin
                        r_state <= i_stat.last_char ? S_EMIT : S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (i_stat.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_take_goes_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_EXEC))
        else $error("accepted item did not enter execution");
    a_emit_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && i_stat.out_free) |=> (r_state == S_IDLE))
        else $error("emit did not complete with a free output register");
`endif

endmodule

>>> rtl/core/cps_datapath.sv
// Datapath of the CIGAR pileup scorer: registers, pileup memory and arithmetic.
module cps_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cps_pkg::t_in_item                 i_in_data,
    input  logic                              i_cfg_we,
    input  logic [cps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cps_pkg::WT_W-1:0]          i_cfg_data,
    input  cps_pkg::t_cmd                     i_cmd,
    output cps_pkg::t_stat                    o_stat,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output cps_pkg::t_out_item                o_out_data
);

    localparam int PROD_W = cps_pkg::RUN_W + cps_pkg::WT_W + 1;

    logic signed [cps_pkg::WT_W-1:0]  r_match;
    logic signed [cps_pkg::WT_W-1:0]  r_mismatch;
    logic signed [cps_pkg::WT_W-1:0]  r_gap_open;
    logic signed [cps_pkg::WT_W-1:0]  r_gap_ext;
    logic [cps_pkg::LEN_W-1:0]        r_len [cps_pkg::NUM_REFS];
    logic [cps_pkg::RUN_W-1:0]        r_run;
    logic [cps_pkg::CUR_W-1:0]        r_cur;
    logic [31:0]                      r_score;
    cps_pkg::t_in_item                r_item;
    logic signed [cps_pkg::WT_W-1:0]  r_cov_w;
    logic [cps_pkg::RUN_W-1:0]        r_idx;
    logic                             r_wr_pend;
    logic [cps_pkg::ADDR_W-1:0]       r_wr_addr;
    logic [63:0]                      r_rd_data;
    logic                             r_rd_zero;
    logic [cps_pkg::ADDR_W-1:0]       r_clr_addr;
    logic                             r_out_valid;
    cps_pkg::t_out_item               r_out_data;
    logic [63:0]                      r_mem [cps_pkg::DEPTH];

    logic                             is_digit;
    logic                             is_match;
    logic                             is_mism;
    logic                             is_del;
    logic                             is_ins;
    logic                             add_prod;
    logic [cps_pkg::RUN_W-1:0]        eff_run;
    logic [cps_pkg::CUR_W-1:0]        eff_cur;
    logic [31:0]                      eff_score;
    logic signed [cps_pkg::WT_W-1:0]  mul_a;
    logic signed [cps_pkg::RUN_W:0]   mul_b;
    logic signed [PROD_W-1:0]         product;
    logic [31:0]                      prod32;
    logic [31:0]                      gap_add;
    logic [cps_pkg::RUN_W+3:0]        run_sum;
    logic [cps_pkg::RUN_W-1:0]        run_dig;
    logic [cps_pkg::CUR_W:0]          del_sum;
    logic [cps_pkg::CUR_W-1:0]        del_cur;
    logic [cps_pkg::CUR_W:0]          cov_sum;
    logic [cps_pkg::CUR_W-1:0]        cov_cur;
    logic [cps_pkg::CUR_W:0]          p;
    logic [cps_pkg::LEN_W-1:0]        cur_len;
    logic                             step_ok;
    logic [cps_pkg::ADDR_W-1:0]       step_addr;
    logic                             rd_en;
    logic [cps_pkg::ADDR_W-1:0]       rd_addr;
    logic                             out_free;
    logic [31:0]                      cov_w32;

    assign is_digit = (r_item.ch >= cps_pkg::CH_0) && (r_item.ch <= cps_pkg::CH_9);
    assign is_match = (r_item.ch == cps_pkg::CH_M) || (r_item.ch == cps_pkg::CH_EQ);
    assign is_mism  = (r_item.ch == cps_pkg::CH_N) || (r_item.ch == cps_pkg::CH_X);
    assign is_del   = (r_item.ch == cps_pkg::CH_D);
    assign is_ins   = (r_item.ch == cps_pkg::CH_I);
    assign add_prod = is_match || is_mism || is_del || is_ins;

    assign eff_run   = r_item.first_char ? '0 : r_run;
    assign eff_cur   = r_item.first_char ? cps_pkg::CUR_W'(r_item.position) : r_cur;
    assign eff_score = r_item.first_char ? 32'd0 : r_score;

    // One shared multiplier: weight times count for runs, extend times count less one for gaps.
    assign mul_a   = is_match ? r_match : (is_mism ? r_mismatch : r_gap_ext);
    assign mul_b   = (is_match || is_mism) ? $signed({1'b0, eff_run})
                                           : $signed({1'b0, eff_run} - 17'd1);
    assign product = mul_a * mul_b;
    assign prod32  = {{(32 - PROD_W){product[PROD_W-1]}}, product};
    assign gap_add = (is_del || is_ins)
                   ? {{(32 - cps_pkg::WT_W){r_gap_open[cps_pkg::WT_W-1]}}, r_gap_open}
                   : 32'd0;

    assign run_sum = {1'b0, eff_run, 3'b000} + {3'b000, eff_run, 1'b0}
                   + {(cps_pkg::RUN_W)'(0), r_item.ch[3:0]};
    assign run_dig = (run_sum > {4'b0000, cps_pkg::RUN_MAX})
                   ? cps_pkg::RUN_MAX : run_sum[cps_pkg::RUN_W-1:0];

    assign del_sum = {1'b0, eff_cur} + (cps_pkg::CUR_W + 1)'(eff_run);
    assign del_cur = del_sum[cps_pkg::CUR_W] ? cps_pkg::CUR_MAX : del_sum[cps_pkg::CUR_W-1:0];
    assign cov_sum = {1'b0, r_cur} + (cps_pkg::CUR_W + 1)'(r_run);
    assign cov_cur = cov_sum[cps_pkg::CUR_W] ? cps_pkg::CUR_MAX : cov_sum[cps_pkg::CUR_W-1:0];

    assign p         = {1'b0, r_cur} + (cps_pkg::CUR_W + 1)'(r_idx);
    assign cur_len   = r_len[r_item.ref_slot];
    assign step_ok   = (r_idx != r_run) && (p < (cps_pkg::CUR_W + 1)'(cur_len));
    assign step_addr = {r_item.ref_slot, p[cps_pkg::POS_W-1:0]};

    assign rd_en   = (i_cmd.run_step && step_ok)
                   || (i_cmd.exec && (r_item.func == cps_pkg::FUNC_READ));
    assign rd_addr = i_cmd.run_step ? step_addr
                   : {r_item.ref_slot, r_item.position[cps_pkg::POS_W-1:0]};

    assign out_free = !r_out_valid || i_out_ready;
    assign cov_w32  = {{(32 - cps_pkg::WT_W){r_cov_w[cps_pkg::WT_W-1]}}, r_cov_w};

    assign o_stat.clear_last = &r_clr_addr;
    assign o_stat.cover_end  = !step_ok;
    assign o_stat.func       = r_item.func;
    assign o_stat.last_char  = r_item.last_char;
    assign o_stat.cover_op   = is_match || is_mism;
    assign o_stat.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem[r_clr_addr] <= 64'd0;
        end else if (r_wr_pend) begin
            r_mem[r_wr_addr] <= {r_rd_data[63:32] + cov_w32, r_rd_data[31:0] + 32'd1};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.exec) begin
            r_cov_w   <= is_match ? r_match : r_mismatch;
            r_rd_zero <= (r_item.position >= cps_pkg::LEN_MAX);
        end
        if (i_cmd.run_step && step_ok) begin
            r_wr_addr <= step_addr;
        end
        if (i_cmd.emit && out_free) begin
            if (r_item.func == cps_pkg::FUNC_READ) begin
                r_out_data.kind           <= cps_pkg::KIND_ENTRY;
                r_out_data.align_score    <= '0;
                r_out_data.entry_score    <= r_rd_zero ? '0 : r_rd_data[63:32];
                r_out_data.entry_coverage <= r_rd_zero ? '0 : r_rd_data[31:0];
            end else begin
                r_out_data.kind           <= cps_pkg::KIND_SCORE;
                r_out_data.align_score    <= r_score;
                r_out_data.entry_score    <= '0;
                r_out_data.entry_coverage <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match     <= 8'sd1;
            r_mismatch  <= -8'sd1;
            r_gap_open  <= -8'sd2;
            r_gap_ext   <= -8'sd1;
            r_len       <= '{default: '0};
            r_run       <= '0;
            r_cur       <= '0;
            r_score     <= '0;
            r_idx       <= '0;
            r_wr_pend   <= 1'b0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    cps_pkg::CFG_MATCH:    r_match    <= i_cfg_data;
                    cps_pkg::CFG_MISMATCH: r_mismatch <= i_cfg_data;
                    cps_pkg::CFG_GAP_OPEN: r_gap_open <= i_cfg_data;
                    cps_pkg::CFG_GAP_EXT:  r_gap_ext  <= i_cfg_data;
                endcase
            end
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.exec) begin
                r_idx <= '0;
                if (r_item.func == cps_pkg::FUNC_LEN) begin
                    r_len[r_item.ref_slot] <= (r_item.position > cps_pkg::LEN_MAX)
                                            ? cps_pkg::LEN_MAX : r_item.position;
                end
                if (r_item.func == cps_pkg::FUNC_CHAR) begin
                    r_score <= add_prod ? (eff_score + prod32 + gap_add) : eff_score;
                    r_cur   <= is_del ? del_cur : eff_cur;
                    if (is_digit) begin
                        r_run <= run_dig;
                    end else if (is_match || is_mism) begin
                        r_run <= eff_run;
                    end else begin
                        r_run <= '0;
                    end
                end
            end
            r_wr_pend <= i_cmd.run_step && step_ok;
            if (i_cmd.run_step) begin
                if (step_ok) begin
                    r_idx <= r_idx + 1'b1;
                end else begin
                    r_cur <= cov_cur;
                    r_run <= '0;
                end
            end
            if (i_cmd.emit && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_wr_after_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pend |-> $past(i_cmd.run_step))
        else $error("pileup write without a preceding coverage read");
    a_no_wr_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |-> !r_wr_pend)
        else $error("pileup update collides with the clearing pass");
`endif

endmodule

>>> rtl/core/cigar_pileup_scorer.sv
// Flow: an item is accepted in the idle state and then executed; an M, =, N or X run
// then walks the reference positions it covers, and a result is emitted once the output register is free.
// Items: a new item is taken only when the last one is through and the block is idle again;
// the coverage loop does one read-modify-write of the pileup memory per cycle.
// Reset: synchronous, active low; a clearing pass zeroes every entry of the pileup
// memory while o_in_ready stays low, and configuration writes are taken meanwhile.
module cigar_pileup_scorer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cps_pkg::t_in_item             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cps_pkg::t_out_item            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [cps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cps_pkg::WT_W-1:0]      i_cfg_data
);

    cps_pkg::t_cmd  cmd;
    cps_pkg::t_stat stat;

    cps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cps_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> test/tb.sv
// Self-checking testbench of the CIGAR pileup scorer: a directed table, then random alignments, reads and lengths.
module tb;
    import cps_pkg::*;

    localparam int STALL_LIMIT = 800000;
    localparam int PHASE_ITEMS = 250;
    localparam logic [7:0] CH_H = 8'h48;

    typedef struct {
        t_in_item  item;
        bit        fixed;
        t_out_item want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_item             in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_MATCH;
    logic [WT_W-1:0]      cfg_data = '0;

    logic [31:0]      pile_score [int unsigned];
    logic [31:0]      pile_cov [int unsigned];
    logic [LEN_W-1:0] slot_len [NUM_REFS] = '{default: '0};
    logic [RUN_W-1:0] run_cnt = '0;
    logic [CUR_W-1:0] cur_pos = '0;
    logic [31:0]      aln_score = '0;
    logic [31:0]      w_match = 32'd1;
    logic [31:0]      w_mismatch = 32'hFFFF_FFFF;
    logic [31:0]      w_open = 32'hFFFF_FFFE;
    logic [31:0]      w_extend = 32'hFFFF_FFFF;

    t_out_item   results_due [$];
    t_row        dir_rows [$];
    bit          fixed_on = 1'b0;
    t_out_item   fixed_out = '0;
    int          mismatches = 0;
    int          quiet = 0;
    int          sent = 0;
    int          snd_idle = 0;
    int          rcv_stall = 0;
    int          snd_pct [4] = '{0, 56, 0, 13};
    int          rcv_pct [4] = '{0, 0, 56, 13};
    logic [7:0]  op_set [6] = '{CH_M, CH_EQ, CH_N, CH_X, CH_D, CH_I};

    cigar_pileup_scorer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= rcv_stall);
    end

    function automatic logic [31:0] score_at(input int unsigned a);
        return pile_score.exists(a) ? pile_score[a] : 32'd0;
    endfunction

    function automatic logic [31:0] cov_at(input int unsigned a);
        return pile_cov.exists(a) ? pile_cov[a] : 32'd0;
    endfunction

    function automatic void advance_pos(input int unsigned cnt);
        int unsigned nxt;
        nxt = cur_pos + cnt;
        cur_pos = (nxt > CUR_MAX) ? CUR_MAX : CUR_W'(nxt);
    endfunction

    function automatic void cover_run(input int unsigned slot, input int unsigned cnt,
                                      input logic [31:0] w);
        int unsigned len, p, a, i;
        len = (slot < NUM_REFS) ? slot_len[slot] : 0;
        for (i = 0; i < cnt; i++) begin
            p = cur_pos + i;
            if (p >= len) break;
            a = slot * MAX_REF_LEN + p;
            pile_score[a] = score_at(a) + w;
            pile_cov[a] = cov_at(a) + 32'd1;
        end
        aln_score += w * cnt;
        advance_pos(cnt);
    endfunction

    // Applies one accepted item to the pileup state; returns 1 when it yields a result.
    function automatic bit apply_cigar_item(input t_in_item it, output t_out_item res);
        int unsigned n, a;
        res = '0;
        case (it.func)
            FUNC_READ: begin
                res.kind = KIND_ENTRY;
                if (it.position < MAX_REF_LEN) begin
                    a = int'(it.ref_slot) * MAX_REF_LEN + int'(it.position);
                    res.entry_score = score_at(a);
                    res.entry_coverage = cov_at(a);
                end
                return 1'b1;
            end
            FUNC_LEN: begin
                slot_len[it.ref_slot] = (it.position > MAX_REF_LEN) ? LEN_MAX : it.position;
                return 1'b0;
            end
            FUNC_CHAR: begin
                if (it.first_char) begin
                    run_cnt = '0;
                    aln_score = '0;
                    cur_pos = CUR_W'(it.position);
                end
                if (it.ch >= CH_0 && it.ch <= CH_9) begin
                    n = run_cnt * 10 + (it.ch - CH_0);
                    run_cnt = (n > RUN_MAX) ? RUN_MAX : RUN_W'(n);
                end else begin
                    case (it.ch)
                        CH_M, CH_EQ: cover_run(it.ref_slot, run_cnt, w_match);
                        CH_N, CH_X: cover_run(it.ref_slot, run_cnt, w_mismatch);
                        CH_D, CH_I: begin
                            aln_score += w_open + w_extend * (32'(run_cnt) - 32'd1);
                            if (it.ch == CH_D) advance_pos(run_cnt);
                        end
                        default: ;
                    endcase
                    run_cnt = '0;
                end
                if (!it.last_char) return 1'b0;
                res.kind = KIND_SCORE;
                res.align_score = aln_score;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    always @(posedge i_clk) begin : check_results
        t_out_item res;
        t_out_item due;
        if (i_rst_n && in_valid && in_ready) begin
            if (apply_cigar_item(in_data, res))
                results_due.insert(results_due.size(), fixed_on ? fixed_out : res);
        end
        if (i_rst_n && out_valid && out_ready) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("tb: result with none expected: %p", out_data);
            end else begin
                due = results_due.pop_front();
                if (out_data.kind !== due.kind || out_data.align_score !== due.align_score ||
                    out_data.entry_score !== due.entry_score ||
                    out_data.entry_coverage !== due.entry_coverage) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("tb: mismatch kind %0d/%0d align %0d/%0d entry %0d/%0d cov %0d/%0d",
                                 due.kind, out_data.kind, due.align_score, out_data.align_score,
                                 due.entry_score, out_data.entry_score,
                                 due.entry_coverage, out_data.entry_coverage);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet <= 0;
        end else begin
            quiet <= quiet + 1;
        end
        if (quiet >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_in_item mk(input t_func f, input logic [7:0] c,
                                    input logic [SLOT_W-1:0] s, input logic [16:0] p,
                                    input bit fc, input bit lc);
        t_in_item it;
        it.func = f;
        it.ch = c;
        it.ref_slot = s;
        it.position = p;
        it.first_char = fc;
        it.last_char = lc;
        return it;
    endfunction

    function automatic void add_row(input t_in_item it, input bit fixed, input t_out_item want);
        dir_rows.insert(dir_rows.size(), '{it, fixed, want});
    endfunction

    function automatic logic [7:0] pick_op();
        logic [7:0] c;
        if ($urandom_range(0, 99) < 88) return op_set[$urandom_range(0, 5)];
        do c = 8'($urandom); while (c >= CH_0 && c <= CH_9);
        return c;
    endfunction

    task automatic set_idle(input int mode);
        snd_idle = snd_pct[mode];
        rcv_stall = rcv_pct[mode];
    endtask

    task automatic send_item(input t_in_item it, input bit fixed = 1'b0,
                             input t_out_item want = '0);
        while ($urandom_range(0, 99) < snd_idle) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        fixed_on = fixed;
        fixed_out = want;
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge i_clk); while (in_ready !== 1'b1);
        @(negedge i_clk);
        if (it.func != FUNC_NONE) sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge i_clk);
        while (results_due.size() != 0) @(negedge i_clk);
    endtask

    // A read returns only after every earlier item has finished, so the block is idle after it.
    task automatic settle();
        send_item(mk(FUNC_READ, 8'h00, '0, 17'd0, 1'b0, 1'b0));
        drain();
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WT_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_MATCH: w_match = {{24{val[7]}}, val};
            CFG_MISMATCH: w_mismatch = {{24{val[7]}}, val};
            CFG_GAP_OPEN: w_open = {{24{val[7]}}, val};
            CFG_GAP_EXT: w_extend = {{24{val[7]}}, val};
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_weights(input logic [7:0] m, input logic [7:0] mm,
                               input logic [7:0] go, input logic [7:0] ge);
        write_reg(CFG_MATCH, m);
        write_reg(CFG_MISMATCH, mm);
        write_reg(CFG_GAP_OPEN, go);
        write_reg(CFG_GAP_EXT, ge);
        cfg_we <= 1'b0;
    endtask

    task automatic send_read();
        logic [SLOT_W-1:0] s;
        logic [16:0]       a;
        s = SLOT_W'($urandom_range(0, NUM_REFS - 1));
        a = ($urandom_range(0, 9) < 7) ? 17'($urandom_range(0, slot_len[s] + 2)) : 17'($urandom);
        send_item(mk(FUNC_READ, 8'($urandom), s, a, 1'($urandom), 1'($urandom)));
    endtask

    task automatic send_length();
        logic [16:0] v;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 75) v = 17'($urandom_range(1, 300));
        else if (pick < 85) v = '0;
        else if (pick < 92) v = 17'($urandom);
        else v = 17'(MAX_REF_LEN);
        send_item(mk(FUNC_LEN, 8'($urandom), SLOT_W'($urandom), v, 1'($urandom), 1'($urandom)));
    endtask

    task automatic send_noise(input bit ignored);
        t_in_item it;
        it = mk(t_func'($urandom_range(0, 3)), 8'($urandom), SLOT_W'($urandom), 17'($urandom),
                1'($urandom), 1'($urandom));
        if (ignored) it.func = FUNC_NONE;
        send_item(it);
    endtask

    // One alignment: digit runs and operation letters; a far one jumps to the end of the
    // position range with long deletions before its last operation.
    task automatic send_alignment(input bit no_first, input bit no_last, input bit far);
        logic [SLOT_W-1:0] slot;
        logic [16:0]       start;
        logic [7:0]        chars [$];
        logic [7:0]        op;
        string             digits;
        int unsigned       nops, pick, cnt, n, k;
        slot = SLOT_W'($urandom_range(0, NUM_REFS - 1));
        if (far) start = 17'($urandom_range(100000, 131071));
        else if ($urandom_range(0, 3) == 0) start = 17'($urandom);
        else start = 17'($urandom_range(0, slot_len[slot]));
        nops = far ? $urandom_range(3, 5) : $urandom_range(1, 6);
        for (n = 0; n < nops; n++) begin
            pick = $urandom_range(0, 99);
            op = pick_op();
            cnt = (pick < 97) ? $urandom_range(1, 30) : $urandom_range(100, 99999);
            if (far && n + 1 < nops) begin
                op = CH_D;
                cnt = 99999;
                pick = 50;
            end
            if (pick >= 8) begin
                digits = $sformatf("%0d", cnt);
                if (pick % 9 == 0) digits = {"0", digits};
                for (k = 0; k < digits.len(); k++) chars.insert(chars.size(), digits[k]);
            end
            chars.insert(chars.size(), op);
        end
        for (k = 0; k < chars.size(); k++)
            send_item(mk(FUNC_CHAR, chars[k],
                         ($urandom_range(0, 9) == 0) ? SLOT_W'($urandom) : slot,
                         (k == 0) ? start : 17'($urandom),
                         k == 0 && !no_first, k + 1 == chars.size() && !no_last));
    endtask

    task automatic run_random(input int target, input bit mixed);
        int goal;
        int unsigned pick;
        goal = sent + target;
        while (sent < goal) begin
            if (mixed) set_idle($urandom_range(0, 3));
            pick = $urandom_range(0, 99);
            if (pick < 66) send_alignment(1'b0, 1'b0, 1'b0);
            else if (pick < 68) send_alignment(1'b0, 1'b0, 1'b1);
            else if (pick < 78) send_read();
            else if (pick < 84) send_length();
            else if (pick < 90) send_noise(1'b0);
            else if (pick < 95) send_alignment(1'($urandom), 1'($urandom), 1'b0);
            else if (pick < 98) send_noise(1'b1);
            else drain();
        end
    endtask

    initial begin
        t_out_item entry_zero;
        t_out_item score_zero;
        t_out_item score_sat;
        t_out_item none;
        none = '0;
        entry_zero = '0;
        entry_zero.kind = KIND_ENTRY;
        score_zero = '0;
        score_zero.kind = KIND_SCORE;
        score_sat = score_zero;
        score_sat.align_score = -32'sd65535;

        add_row(mk(FUNC_READ, 8'h00, 2'd0, 17'd0, 1'b0, 1'b0), 1'b1, entry_zero);
        add_row(mk(FUNC_READ, 8'hFF, 2'd3, 17'h1FFFF, 1'b1, 1'b1), 1'b1, entry_zero);
        add_row(mk(FUNC_LEN, 8'h00, 2'd0, 17'd20, 1'b0, 1'b0), 1'b0, none);
        add_row(mk(FUNC_LEN, 8'h00, 2'd1, 17'h1FFFF, 1'b0, 1'b0), 1'b0, none);
        add_row(mk(FUNC_LEN, 8'h00, 2'd2, 17'd5, 1'b0, 1'b0), 1'b0, none);
        add_row(mk(FUNC_CHAR, CH_0 + 8'd5, 2'd0, 17'd3, 1'b1, 1'b0), 1'b0, none);
        add_row(mk(FUNC_CHAR, CH_M, 2'd0, 17'd0, 1'b0, 1'b0), 1'b0, none);
        add_row(mk(FUNC_CHAR, CH_0 + 8'd2, 2'd0, 17'd0, 1'b0, 1'b0), 1'b0, none);
        add_row(mk(FUNC_CHAR, CH_I, 2'd0, 17'd0, 1'b0, 1'b0), 1'b0, none);
        add_row(mk(FUNC_CHAR, CH_D, 2'd0, 17'd0, 1'b0, 1'b0), 1'b0, none);
        add_row(mk(FUNC_CHAR, CH_0 + 8'd3, 2'd0, 17'd0, 1'b0, 1'b0), 1'b0, none);
        add_row(mk(FUNC_CHAR, CH_X, 2'd0, 17'd0, 1'b0, 1'b1), 1'b0, none);
        add_row(mk(FUNC_CHAR, CH_0, 2'd0, 17'd0, 1'b1, 1'b1), 1'b1, score_zero);
        add_row(mk(FUNC_NONE, 8'hFF, 2'd3, 17'h1FFFF, 1'b1, 1'b1), 1'b0, none);
        add_row(mk(FUNC_CHAR, CH_9, 2'd1, 17'd65530, 1'b1, 1'b0), 1'b0, none);
        add_row(mk(FUNC_CHAR, CH_EQ, 2'd1, 17'd0, 1'b0, 1'b1), 1'b0, none);
        add_row(mk(FUNC_READ, 8'h00, 2'd1, 17'd65535, 1'b0, 1'b0), 1'b0, none);
        add_row(mk(FUNC_CHAR, CH_9, 2'd2, 17'h1FFFF, 1'b1, 1'b0), 1'b0, none);
        repeat (4) add_row(mk(FUNC_CHAR, CH_9, 2'd2, 17'd0, 1'b0, 1'b0), 1'b0, none);
        add_row(mk(FUNC_CHAR, CH_N, 2'd2, 17'd0, 1'b0, 1'b1), 1'b1, score_sat);
        add_row(mk(FUNC_READ, 8'h00, 2'd0, 17'd7, 1'b0, 1'b0), 1'b0, none);
        add_row(mk(FUNC_CHAR, CH_H, 2'd3, 17'd9, 1'b1, 1'b1), 1'b1, score_zero);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_idle(0);
        foreach (dir_rows[r]) send_item(dir_rows[r].item, dir_rows[r].fixed, dir_rows[r].want);
        run_random(PHASE_ITEMS - dir_rows.size(), 1'b0);
        settle();

        set_idle(1);
        set_weights(8'd127, 8'h80, 8'h80, 8'd127);
        run_random(PHASE_ITEMS, 1'b0);
        settle();

        set_idle(2);
        set_weights(8'h80, 8'd127, 8'd127, 8'h80);
        run_random(PHASE_ITEMS, 1'b0);
        settle();

        set_idle(3);
        set_weights(8'd0, 8'd0, 8'd0, 8'd0);
        run_random(PHASE_ITEMS, 1'b0);
        settle();

        set_weights(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        run_random(PHASE_ITEMS, 1'b1);
        drain();
        repeat (20) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/cps_pkg.sv
rtl/core/cps_ctrl.sv
rtl/core/cps_datapath.sv
rtl/core/cigar_pileup_scorer.sv
test/tb.sv
